// ----- hdl/assert_macros.svh -----
// Assertion macros for the hit to sector and pad row mapper.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/hsp_pkg.sv -----
// Shared types, constants and the arctangent table of the hit mapper.
// No dependencies.
package hsp_pkg;

   localparam int XY_W             = 28;
   localparam int ANG_W            = 18;
   localparam int REM_W            = 20;
   localparam int ATAN_ENTRIES     = 24;
   localparam int SECTORS_DEF      = 12;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int MARGIN_W         = 655;
   localparam int GAIN_Q16         = 39797;
   localparam int ROW_BITS         = 8;

   localparam logic [2:0] REG_INNER_RADIUS    = 3'd0;
   localparam logic [2:0] REG_BOUNDARY_RADIUS = 3'd1;
   localparam logic [2:0] REG_OUTER_RADIUS    = 3'd2;
   localparam logic [2:0] REG_INNER_PAD_H     = 3'd3;
   localparam logic [2:0] REG_OUTER_PAD_H     = 3'd4;
   localparam logic [2:0] REG_INNER_ROWS      = 3'd5;
   localparam logic [2:0] REG_PHASE_OFFSET    = 3'd6;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [4:0]         sector;
      logic [6:0]         base;
      logic signed [17:0] local_across;
      logic [15:0]        local_radial;
      logic signed [16:0] local_z;
      logic               outside;
      logic               sat;
      logic [11:0]        dvs;
      logic [REM_W-1:0]   rem;
      logic [ROW_BITS-1:0] quo;
   } div_type;

   typedef struct packed {
      logic signed [16:0] local_z;
      logic [15:0]        local_radial;
      logic signed [17:0] local_across;
      logic [7:0]         pad_row;
      logic [4:0]         sector;
   } res_type;

   typedef struct packed {
      logic    outside;
      res_type res;
   } out_type;

   function automatic logic signed [ANG_W-1:0] atan_turn(input int idx);
      logic signed [ANG_W-1:0] v;
      unique case (idx)
         0:  v = 18'sd8192;
         1:  v = 18'sd4836;
         2:  v = 18'sd2555;
         3:  v = 18'sd1297;
         4:  v = 18'sd651;
         5:  v = 18'sd326;
         6:  v = 18'sd163;
         7:  v = 18'sd81;
         8:  v = 18'sd41;
         9:  v = 18'sd20;
         10: v = 18'sd10;
         11: v = 18'sd5;
         12: v = 18'sd3;
         13: v = 18'sd1;
         14: v = 18'sd1;
         default: v = 18'sd0;
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/hit_to_sector_padrow.sv -----
// Hit to sector and pad row mapper: one hit in and one result out per clock
// while not stalled. The path runs through the two chains of CORDIC cells
// (azimuth, then rotation into the sector frame) and the eight-cell row
// divider; a new item is taken every cycle while the two-entry result
// queue has room. Depends on hsp_pkg, the cell modules and hsp_out_queue.
`include "assert_macros.svh"
module hit_to_sector_padrow import hsp_pkg::*; #(
   parameter int SECTORS      = SECTORS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // glob_x[16:0], glob_y[33:17], glob_z[50:34], given_sector[55:51]
   input  logic [55:0] req_tdata,
   // sector_given[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // sector[4:0], pad_row[12:5], local_across[30:13], local_radial[46:31],
   // local_z[63:47]
   output logic [63:0] rsp_tdata,
   // outside[0]
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AZ_TAG_W  = 57;
   localparam int ROT_TAG_W = 22;

   logic [15:0] inner_ff, bound_ff, outer_ff, phase_ff;
   logic [11:0] inner_h_ff, outer_h_ff;
   logic [6:0]  rows_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff   <= 16'd9216;
         bound_ff   <= 16'd17510;
         outer_ff   <= 16'd29491;
         inner_h_ff <= 12'd307;
         outer_h_ff <= 12'd461;
         rows_ff    <= 7'd27;
         phase_ff   <= 16'd62805;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_INNER_RADIUS:    inner_ff   <= csr_pwdata[15:0];
            REG_BOUNDARY_RADIUS: bound_ff   <= csr_pwdata[15:0];
            REG_OUTER_RADIUS:    outer_ff   <= csr_pwdata[15:0];
            REG_INNER_PAD_H:     inner_h_ff <= csr_pwdata[11:0];
            REG_OUTER_PAD_H:     outer_h_ff <= csr_pwdata[11:0];
            REG_INNER_ROWS:      rows_ff    <= csr_pwdata[6:0];
            REG_PHASE_OFFSET:    phase_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_INNER_RADIUS:    csr_prdata = {16'd0, inner_ff};
         REG_BOUNDARY_RADIUS: csr_prdata = {16'd0, bound_ff};
         REG_OUTER_RADIUS:    csr_prdata = {16'd0, outer_ff};
         REG_INNER_PAD_H:     csr_prdata = {20'd0, inner_h_ff};
         REG_OUTER_PAD_H:     csr_prdata = {20'd0, outer_h_ff};
         REG_INNER_ROWS:      csr_prdata = {25'd0, rows_ff};
         REG_PHASE_OFFSET:    csr_prdata = {16'd0, phase_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   logic en, q_full;
   assign en         = !q_full;
   assign req_tready = en;

   // input stage: scale to working units, fold left half-plane
   logic                   pre_valid_ff;
   cordic_type             pre_vec_ff, pre_vec_in;
   logic [AZ_TAG_W-1:0]    pre_tag_ff;
   logic signed [XY_W-1:0] gx, gy;

   always_comb begin
      gx = {{(XY_W-25){req_tdata[16]}}, req_tdata[16:0], 8'd0};
      gy = {{(XY_W-25){req_tdata[33]}}, req_tdata[33:17], 8'd0};
      if (gx < 0) begin
         pre_vec_in.x = -gx;
         pre_vec_in.y = -gy;
         pre_vec_in.z = 18'sd32768;
      end else begin
         pre_vec_in.x = gx;
         pre_vec_in.y = gy;
         pre_vec_in.z = 18'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (en) begin
         pre_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_vec_ff <= pre_vec_in;
         pre_tag_ff <= {req_tdata[55:51], req_tuser, req_tdata[50:0]};
      end
   end

   // azimuth chain
   logic                az_valid [CORDIC_STEPS+1];
   cordic_type          az_vec   [CORDIC_STEPS+1];
   logic [AZ_TAG_W-1:0] az_tag   [CORDIC_STEPS+1];

   assign az_valid[0] = pre_valid_ff;
   assign az_vec[0]   = pre_vec_ff;
   assign az_tag[0]   = pre_tag_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_az
      hsp_cordic_cell #(.STEP(i), .VECTOR(1'b1), .TAG_W(AZ_TAG_W)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(az_valid[i]), .in_vec(az_vec[i]), .in_tag(az_tag[i]),
         .out_valid(az_valid[i+1]), .out_vec(az_vec[i+1]), .out_tag(az_tag[i+1])
      );
   end

   // sector stage
   logic                    sec_valid_ff;
   logic [4:0]              sec_ff, sec_in;
   logic [50:0]             sec_tag_ff;
   logic [15:0]             d16;
   logic [21:0]             prod;
   logic [5:0]              gmod;
   logic [AZ_TAG_W-1:0]     az_last;

   assign az_last = az_tag[CORDIC_STEPS];

   always_comb begin
      d16  = az_vec[CORDIC_STEPS].z[15:0] - phase_ff;
      prod = 22'(d16) * 22'(SECTORS);
      gmod = {1'b0, az_last[56:52]};
      for (int k = 0; k < 8; k++) begin
         if (gmod >= 6'(SECTORS)) begin
            gmod = gmod - 6'(SECTORS);
         end
      end
      sec_in = az_last[51] ? gmod[4:0] : prod[20:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_valid_ff <= 1'b0;
      end else if (en) begin
         sec_valid_ff <= az_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sec_ff     <= sec_in;
         sec_tag_ff <= az_last[50:0];
      end
   end

   // rotation set-up: sector angle, fold into the right half-plane
   logic [15:0]             theta_tab [32];
   logic [15:0]             ang16;
   logic signed [ANG_W-1:0] zs;
   logic signed [XY_W-1:0]  hx, hy;
   logic                    rp_valid_ff;
   cordic_type              rp_vec_ff, rp_vec_in;
   logic [ROT_TAG_W-1:0]    rp_tag_ff;

   for (genvar g = 0; g < 32; g++) begin : g_theta
      localparam int TH = (g * 65536) / SECTORS;
      assign theta_tab[g] = 16'(TH);
   end

   always_comb begin
      ang16 = 16'd0 - theta_tab[sec_ff];
      zs    = {{(ANG_W-16){ang16[15]}}, ang16};
      hx    = {{(XY_W-25){sec_tag_ff[16]}}, sec_tag_ff[16:0], 8'd0};
      hy    = {{(XY_W-25){sec_tag_ff[33]}}, sec_tag_ff[33:17], 8'd0};
      rp_vec_in.x = hx;
      rp_vec_in.y = hy;
      rp_vec_in.z = zs;
      if (zs > 18'sd16384) begin
         rp_vec_in.x = -hx;
         rp_vec_in.y = -hy;
         rp_vec_in.z = zs - 18'sd32768;
      end else if (zs < -18'sd16384) begin
         rp_vec_in.x = -hx;
         rp_vec_in.y = -hy;
         rp_vec_in.z = zs + 18'sd32768;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_valid_ff <= 1'b0;
      end else if (en) begin
         rp_valid_ff <= sec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rp_vec_ff <= rp_vec_in;
         rp_tag_ff <= {sec_tag_ff[50:34], sec_ff};
      end
   end

   // rotation chain
   logic                 rot_valid [CORDIC_STEPS+1];
   cordic_type           rot_vec   [CORDIC_STEPS+1];
   logic [ROT_TAG_W-1:0] rot_tag   [CORDIC_STEPS+1];

   assign rot_valid[0] = rp_valid_ff;
   assign rot_vec[0]   = rp_vec_ff;
   assign rot_tag[0]   = rp_tag_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      hsp_cordic_cell #(.STEP(i), .VECTOR(1'b0), .TAG_W(ROT_TAG_W)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(rot_valid[i]), .in_vec(rot_vec[i]), .in_tag(rot_tag[i]),
         .out_valid(rot_valid[i+1]), .out_vec(rot_vec[i+1]), .out_tag(rot_tag[i+1])
      );
   end

   // gain correction
   localparam logic signed [17:0] GAIN_S = 18'(GAIN_Q16);
   logic signed [XY_W+17:0] px, py;
   logic                    gn_valid_ff;
   logic signed [XY_W-1:0]  gn_x_ff, gn_y_ff;
   logic [ROT_TAG_W-1:0]    gn_tag_ff;

   assign px = rot_vec[CORDIC_STEPS].x * GAIN_S;
   assign py = rot_vec[CORDIC_STEPS].y * GAIN_S;

   always_ff @(posedge clock) begin
      if (reset) begin
         gn_valid_ff <= 1'b0;
      end else if (en) begin
         gn_valid_ff <= rot_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gn_x_ff   <= px[XY_W+15:16];
         gn_y_ff   <= py[XY_W+15:16];
         gn_tag_ff <= rot_tag[CORDIC_STEPS];
      end
   end

   // window check, region select and divider set-up
   logic signed [XY_W-1:0] lo, hi, bd, lo_m, hi_m, rlo, rbd, acr;
   logic                   in_region;
   div_type                d0_in;
   logic                   d0_valid_ff;
   div_type                d0_ff;

   always_comb begin
      lo   = XY_W'({inner_ff, 8'd0});
      hi   = XY_W'({outer_ff, 8'd0});
      bd   = XY_W'({bound_ff, 8'd0});
      lo_m = lo + XY_W'(MARGIN_W);
      hi_m = hi - XY_W'(MARGIN_W);
      rlo  = (gn_x_ff - lo) >>> 8;
      rbd  = (gn_x_ff - bd) >>> 8;
      acr  = (gn_y_ff + XY_W'(128)) >>> 8;
      in_region = (gn_x_ff <= bd);
      d0_in.sector       = gn_tag_ff[4:0];
      d0_in.local_z      = gn_tag_ff[21:5];
      d0_in.local_radial = rlo[15:0];
      d0_in.outside      = (gn_x_ff < lo_m) || (gn_x_ff > hi_m);
      if (acr > XY_W'(131071)) begin
         d0_in.local_across = 18'sd131071;
      end else if (acr < -XY_W'(131072)) begin
         d0_in.local_across = -18'sd131072;
      end else begin
         d0_in.local_across = acr[17:0];
      end
      if (in_region) begin
         d0_in.base = 7'd0;
         d0_in.dvs  = inner_h_ff;
         d0_in.rem  = rlo[REM_W-1:0];
      end else begin
         d0_in.base = rows_ff;
         d0_in.dvs  = outer_h_ff;
         d0_in.rem  = rbd[REM_W-1:0];
      end
      d0_in.sat = (d0_in.rem >= {d0_in.dvs, 8'd0});
      d0_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_valid_ff <= 1'b0;
      end else if (en) begin
         d0_valid_ff <= gn_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff <= d0_in;
      end
   end

   // row divider chain, most significant quotient bit first
   logic    dv_valid [ROW_BITS+1];
   div_type dv_item  [ROW_BITS+1];

   assign dv_valid[0] = d0_valid_ff;
   assign dv_item[0]  = d0_ff;

   for (genvar i = 0; i < ROW_BITS; i++) begin : g_div
      hsp_div_cell #(.BIT(ROW_BITS-1-i)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(dv_valid[i]), .in_item(dv_item[i]),
         .out_valid(dv_valid[i+1]), .out_item(dv_item[i+1])
      );
   end

   // result assembly
   div_type    fin;
   logic [7:0] row_q;
   logic [8:0] row_sum;
   out_type    res_in, q_data;
   logic       q_valid;

   always_comb begin
      fin     = dv_item[ROW_BITS];
      row_q   = fin.sat ? 8'd255 : fin.quo;
      row_sum = {1'b0, row_q} + 9'(fin.base);
      res_in  = '0;
      if (fin.outside) begin
         res_in.outside = 1'b1;
      end else begin
         res_in.res.sector       = fin.sector;
         res_in.res.pad_row      = row_sum[8] ? 8'd255 : row_sum[7:0];
         res_in.res.local_across = fin.local_across;
         res_in.res.local_radial = fin.local_radial;
         res_in.res.local_z      = fin.local_z;
      end
   end

   hsp_out_queue u_queue (
      .clock(clock), .reset(reset),
      .push(en && dv_valid[ROW_BITS]), .push_data(res_in),
      .pop_ready(rsp_tready), .full(q_full),
      .valid(q_valid), .data(q_data)
   );

   assign rsp_tvalid = q_valid;
   assign rsp_tdata  = q_data.res;
   assign rsp_tuser  = q_data.outside;

   `ASSERT_IMPLIES(a_outside_zero, clock, reset, rsp_tvalid && rsp_tuser, q_data.res == '0)
   `ASSERT_IMPLIES(a_sector_range, clock, reset, rsp_tvalid && !rsp_tuser, 32'(q_data.res.sector) < SECTORS)
   `ASSERT_IMPLIES(a_radial_margin, clock, reset, rsp_tvalid && !rsp_tuser, q_data.res.local_radial >= 16'd2)
   `ASSERT_NEXT(a_full_stalls, clock, reset, q_full && !rsp_tready, !req_tready)

endmodule

// ----- hdl/hsp_cordic_cell.sv -----
// One CORDIC micro-rotation cell, vectoring or rotating, with a side tag.
// Depends on hsp_pkg.
module hsp_cordic_cell import hsp_pkg::*; #(
   parameter int STEP   = 0,
   parameter bit VECTOR = 1'b1,
   parameter int TAG_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  cordic_type       in_vec,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output cordic_type       out_vec,
   output logic [TAG_W-1:0] out_tag
);

   logic                    valid_ff;
   cordic_type              vec_ff, vec_in;
   logic [TAG_W-1:0]        tag_ff;
   logic signed [XY_W-1:0]  dx, dy;
   logic signed [ANG_W-1:0] turn;
   logic                    up;

   always_comb begin
      dx   = in_vec.y >>> STEP;
      dy   = in_vec.x >>> STEP;
      turn = atan_turn(STEP);
      up   = VECTOR ? (in_vec.y > 0) : (in_vec.z < 0);
      if (up) begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + turn;
      end else begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - turn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_tag   = tag_ff;

endmodule

// ----- hdl/hsp_div_cell.sv -----
// One restoring-division cell: decides one quotient bit of the pad row.
// Depends on hsp_pkg.
module hsp_div_cell import hsp_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  div_type in_item,
   output logic    out_valid,
   output div_type out_item
);

   logic             valid_ff;
   div_type          item_ff, item_in;
   logic [REM_W-1:0] shifted;

   always_comb begin
      item_in = in_item;
      shifted = REM_W'(in_item.dvs) << BIT;
      if (!in_item.sat && in_item.rem >= shifted) begin
         item_in.rem      = in_item.rem - shifted;
         item_in.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- hdl/hsp_out_queue.sv -----
// Two-entry result queue between the pipeline and the result channel.
// Depends on hsp_pkg.
module hsp_out_queue import hsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  out_type push_data,
   input  logic    pop_ready,
   output logic    full,
   output logic    valid,
   output out_type data
);

   out_type    ent_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop   = pop_ready && (count_ff != 2'd0);
   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign data  = ent_ff[rd_ff];

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- tb/sv/hit_to_sector_padrow_check.sv -----
// Checker for the hit to sector and pad row mapper: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on hsp_pkg for the result layout and register indexes.
module hit_to_sector_padrow_check import hsp_pkg::*; #(
   parameter int SECTORS      = 12,
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending,
   output int          results_seen,
   output int          outside_seen
);

   localparam longint MARGIN = 655;
   localparam longint GAIN   = 39797;

   longint unsigned r_inner, r_boundary, r_outer, h_inner, h_outer, rows_inner, phase;
   out_type expected_hits[$];

   function automatic longint arc_step(input int i);
      longint tbl[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
      return (i < 15) ? tbl[i] : 0;
   endfunction

   function automatic logic [15:0] hit_azimuth(input longint x_in, input longint y_in);
      longint x, y, a, dx, dy;
      x = x_in;
      y = y_in;
      a = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         a = 32768;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; a += arc_step(i);
         end else begin
            x -= dx; y += dy; a -= arc_step(i);
         end
      end
      return a[15:0];
   endfunction

   function automatic void rotate_to_sector(inout longint x, inout longint y,
                                            input logic [15:0] ang);
      longint z, dx, dy;
      z = ang;
      if (z >= 32768) z -= 65536;
      if (z > 16384) begin
         x = -x; y = -y; z -= 32768;
      end else if (z < -16384) begin
         x = -x; y = -y; z += 32768;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arc_step(i);
         end else begin
            x += dx; y -= dy; z += arc_step(i);
         end
      end
      x = (x * GAIN) >>> 16;
      y = (y * GAIN) >>> 16;
   endfunction

   function automatic out_type map_hit(input logic [55:0] d, input logic use_given);
      out_type r;
      logic signed [16:0] gx, gy;
      longint rx, ry, lo, hi, bd, across;
      longint unsigned sec, theta, row;
      logic [15:0] dphi;
      gx = d[16:0];
      gy = d[33:17];
      rx = longint'(gx) * 256;
      ry = longint'(gy) * 256;
      lo = r_inner * 256;
      hi = r_outer * 256;
      bd = r_boundary * 256;
      r = '0;
      if (use_given) begin
         sec = d[55:51] % SECTORS;
      end else begin
         dphi = hit_azimuth(rx, ry) - phase[15:0];
         sec = (longint'(dphi) * SECTORS) >> 16;
      end
      theta = (sec * 65536) / SECTORS;
      rotate_to_sector(rx, ry, 16'((65536 - theta) & 16'hFFFF));
      if (rx < lo + MARGIN || rx > hi - MARGIN) begin
         r.outside = 1'b1;
         return r;
      end
      if (rx <= bd)
         row = (h_inner == 0) ? 255 : longint'(rx - lo) / (h_inner * 256);
      else
         row = (h_outer == 0) ? 255 : rows_inner + longint'(rx - bd) / (h_outer * 256);
      if (row > 255) row = 255;
      across = (ry + 128) >>> 8;
      if (across > 131071) across = 131071;
      if (across < -131072) across = -131072;
      r.res.sector       = sec[4:0];
      r.res.pad_row      = row[7:0];
      r.res.local_across = across[17:0];
      r.res.local_radial = 16'((rx - lo) >> 8);
      r.res.local_z      = d[50:34];
      return r;
   endfunction

   always @(posedge clock) begin
      out_type got, want;
      if (reset) begin
         r_inner    <= 9216;
         r_boundary <= 17510;
         r_outer    <= 29491;
         h_inner    <= 307;
         h_outer    <= 461;
         rows_inner <= 27;
         phase      <= 62805;
         fail_count   = 0;
         results_seen = 0;
         outside_seen = 0;
         expected_hits.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[4:2])
               REG_INNER_RADIUS:    r_inner    <= csr_pwdata[15:0];
               REG_BOUNDARY_RADIUS: r_boundary <= csr_pwdata[15:0];
               REG_OUTER_RADIUS:    r_outer    <= csr_pwdata[15:0];
               REG_INNER_PAD_H:     h_inner    <= csr_pwdata[11:0];
               REG_OUTER_PAD_H:     h_outer    <= csr_pwdata[11:0];
               REG_INNER_ROWS:      rows_inner <= csr_pwdata[6:0];
               REG_PHASE_OFFSET:    phase      <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_hits.push_back(map_hit(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            got.outside = rsp_tuser;
            got.res     = rsp_tdata;
            results_seen++;
            if (got.outside) outside_seen++;
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result %h outside %b", $time, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_hits.pop_front();
               if (got.outside !== want.outside) begin
                  $display("%0t: outside exp %b got %b", $time, want.outside, got.outside);
                  fail_count++;
               end
               if (got.res.sector !== want.res.sector) begin
                  $display("%0t: sector exp %0d got %0d", $time, want.res.sector,
                           got.res.sector);
                  fail_count++;
               end
               if (got.res.pad_row !== want.res.pad_row) begin
                  $display("%0t: pad_row exp %0d got %0d", $time, want.res.pad_row,
                           got.res.pad_row);
                  fail_count++;
               end
               if (got.res.local_across !== want.res.local_across) begin
                  $display("%0t: local_across exp %0d got %0d", $time,
                           want.res.local_across, got.res.local_across);
                  fail_count++;
               end
               if (got.res.local_radial !== want.res.local_radial) begin
                  $display("%0t: local_radial exp %0d got %0d", $time,
                           want.res.local_radial, got.res.local_radial);
                  fail_count++;
               end
               if (got.res.local_z !== want.res.local_z) begin
                  $display("%0t: local_z exp %0d got %0d", $time, want.res.local_z,
                           got.res.local_z);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_hits.size();
   end

endmodule

// ----- tb/sv/hit_to_sector_padrow_test.sv -----
// Top of the hit mapper testbench: clock, reset, register writes, hit stimulus
// and the verdict. Depends on hsp_pkg, hit_to_sector_padrow and the checker.
module hit_to_sector_padrow_test;
   import hsp_pkg::*;

   localparam int LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count, pending, results_seen, outside_seen;
   int send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0, cycles = 0, sent = 0;

   hit_to_sector_padrow DUT (.*);
   hit_to_sector_padrow_check checker_inst (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("hit_to_sector_padrow_test: errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_paddr = {idx, 2'b00}; csr_pwdata = val;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
   endtask

   task automatic write_all(input int ri, rb, ro, hi, ho, nr, ph);
      write_reg(REG_INNER_RADIUS, ri);
      write_reg(REG_BOUNDARY_RADIUS, rb);
      write_reg(REG_OUTER_RADIUS, ro);
      write_reg(REG_INNER_PAD_H, hi);
      write_reg(REG_OUTER_PAD_H, ho);
      write_reg(REG_INNER_ROWS, nr);
      write_reg(REG_PHASE_OFFSET, ph);
   endtask

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_hit(input logic [16:0] x, y, z, input logic sg, input logic [4:0] gs);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {gs, z, y, x};
      req_tuser  = sg;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic random_hits(input int n);
      logic [16:0] x, y;
      int kind;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(9);
         if (kind < 6) begin
            x = 17'($signed($urandom_range(0, 64000)) - 32000);
            y = 17'($signed($urandom_range(0, 64000)) - 32000);
         end else begin
            x = 17'($urandom);
            y = 17'($urandom);
         end
         send_hit(x, y, 17'($urandom), (kind >= 8) ? 1'b1 : ($urandom_range(3) == 0),
                  5'($urandom));
         if (i == n / 3) hold_cycles = 300;
         if (i == n / 2) begin
            req_tvalid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;
      write_all(9216, 17510, 29491, 307, 461, 27, 62805);
      @(negedge clock);
      send_hit(17'h10000, 17'h10000, 17'h10000, 1'b0, 5'd0);
      send_hit(17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 1'b0, 5'd31);
      send_hit(17'h10000, 17'h0FFFF, 17'h00000, 1'b1, 5'd31);
      send_hit(17'h0, 17'h0, 17'h0, 1'b0, 5'd0);
      send_hit(17'd9216 + 3, 17'd0, 17'd5, 1'b0, 5'd0);
      send_hit(17'd9216 + 2, 17'd0, 17'd5, 1'b1, 5'd0);
      send_hit(17'd9216, 17'd0, 17'd5, 1'b1, 5'd0);
      send_hit(17'd17510, 17'd0, 17'h1ABCD, 1'b1, 5'd0);
      send_hit(17'd17511, 17'd0, 17'h1ABCD, 1'b1, 5'd0);
      send_hit(17'd29488, 17'd0, 17'd7, 1'b1, 5'd0);
      send_hit(17'd29490, 17'd0, 17'd7, 1'b1, 5'd0);
      send_hit(17'd20000, 17'd0, 17'd1, 1'b1, 5'd12);
      send_hit(17'd0, 17'd20000, 17'd1, 1'b0, 5'd0);
      send_hit(-17'sd20000, 17'd0, 17'd1, 1'b0, 5'd0);
      send_hit(17'd0, -17'sd20000, 17'd1, 1'b0, 5'd0);
      send_hit(17'd14000, 17'd14000, 17'd1, 1'b0, 5'd0);
      send_hit(-17'sd14000, -17'sd14000, 17'd1, 1'b0, 5'd0);
      send_hit(17'd20000, 17'd65535, 17'd1, 1'b1, 5'd0);
      drain();
      send_idle_pct = 11; recv_stall_pct = 74;
      random_hits(300);
      drain();
      write_all(0, 0, 65535, 0, 1, 127, 0);
      send_idle_pct = 74; recv_stall_pct = 11;
      random_hits(300);
      drain();
      write_all(65535, 65535, 0, 4095, 0, 0, 65535);
      send_idle_pct = 0; recv_stall_pct = 0;
      random_hits(40);
      drain();
      write_all(4000, 30000, 20000, 1, 4095, 100, 12345);
      random_hits(260);
      drain();
      $display("%0d hits sent over four register settings, %0d results, %0d outside",
               sent, results_seen, outside_seen);
      $display("directed edge hits, computed and given sectors, stalls and back-pressure");
      if (fail_count == 0)
         $display("hit_to_sector_padrow_test: clean");
      else
         $display("hit_to_sector_padrow_test: errors");
      $finish;
   end

endmodule

// ----- hit_to_sector_padrow.f -----
+incdir+hdl
hdl/hsp_pkg.sv
hdl/hsp_cordic_cell.sv
hdl/hsp_div_cell.sv
hdl/hsp_out_queue.sv
hdl/hit_to_sector_padrow.sv
tb/sv/hit_to_sector_padrow_check.sv
tb/sv/hit_to_sector_padrow_test.sv
